// ===== src/dhti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dhti_pkg;
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SIZE_W   = IDX_W + 1;
    localparam int REL_W    = 10;

    localparam logic [REL_W-1:0]  REL_MAX     = {REL_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(1021);
    localparam logic [SIZE_W-1:0] SIZE_MAX    = SIZE_W'(CAPACITY);

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_QUERY    = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [31:0] H1_SEED   = 32'h7FFF_FFFF;
    localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;

    typedef struct packed {
        logic             busy;
        logic [31:0]      key;
        logic [REL_W-1:0] rel;
        logic [31:0]      value;
    } t_slot;
endpackage
`default_nettype wire

// ===== src/double_hash_table_insert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Double-hashed open-addressed table, duplicate keys kept.
// Input stream s_axis: tuser = req_type (0 insert, 1 query), tdata = key, value.
// Output stream m_axis: one beat per input beat; tuser = status,
// tdata = slot_index, release_count, result_key.
// Config: i_cfg_we writes table_size from i_cfg_wdata; write only when idle.
// Insert: the decimal digits of the key feed the home hash and a digit sum,
// then three 32-step restoring remainders (step hash, home slot, wrap offset;
// the step hash is skipped when table_size is 1) precede the probes; each
// probe is one read of the slot memory.
// A full table is answered without hashing. A query scans each slot of the table,
// one memory read per slot. One item is in work at a time.
// After reset a clearing pass over all CAPACITY (1024) slots empties the slot
// memory; s_axis_tready stays low meanwhile.
// The result sits in an output register; the next beat is accepted while
// it waits. If the sink stalls, a finishing item holds until the register
// frees, with no state lost.
module double_hash_table_insert (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [dhti_pkg::SIZE_W-1:0]       i_cfg_wdata,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [63:0]                       s_axis_tdata,  // key, value
    input  wire  [0:0]                        s_axis_tuser,  // req_type
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [55:0]                       m_axis_tdata,  // slot_index, release_count, result_key, pad
    output logic [1:0]                        m_axis_tuser   // status
);
    import dhti_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_DIG   = 4'd3;
    localparam logic [3:0] S_MOD2  = 4'd4;
    localparam logic [3:0] S_MOD1  = 4'd5;
    localparam logic [3:0] S_MODW  = 4'd6;
    localparam logic [3:0] S_PROBE = 4'd7;
    localparam logic [3:0] S_QSCAN = 4'd8;

    t_slot             mem [CAPACITY];
    t_slot             r_rdata;
    logic [3:0]        r_state;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_entries;
    logic              r_req;
    logic [31:0]       r_key;
    logic [31:0]       r_value;
    logic [31:0]       r_k;
    logic [31:0]       r_h1;
    logic [6:0]        r_dsum;
    logic [31:0]       r_dvd;
    logic [IDX_W-1:0]  r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [4:0]        r_cnt;
    logic [IDX_W-1:0]  r_h2;
    logic [IDX_W-1:0]  r_h2m;
    logic [IDX_W-1:0]  r_h1m;
    logic [IDX_W-1:0]  r_wrapc;
    logic [IDX_W-1:0]  r_pos;
    logic [31:0]       r_p;
    logic [SIZE_W-1:0] r_i;
    logic [REL_W-1:0]  r_rel;
    logic [SIZE_W-1:0] r_j;
    logic              r_found;
    logic [REL_W-1:0]  r_best;
    logic [31:0]       r_ans;
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [IDX_W-1:0]  r_oslot;
    logic [REL_W-1:0]  r_orel;
    logic [31:0]       r_okey;

    logic [SIZE_W-1:0] size;
    logic              out_free;
    logic [63:0]       prod;
    logic [28:0]       quo;
    logic [3:0]        digit;
    logic [SIZE_W-1:0] mod_t;
    logic              mod_ge;
    logic [IDX_W-1:0]  rem_nx;
    logic [SIZE_W-1:0] wrap_p1;
    logic [32:0]       p_sum;
    logic [SIZE_W-1:0] pos_a;
    logic [SIZE_W-1:0] pos_b;
    logic [SIZE_W-1:0] pos_c;
    logic [IDX_W-1:0]  pos_nx;
    logic              key_eq;
    logic              probe_last;
    logic [SIZE_W-1:0] j_nx;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    t_slot             mem_wd;

    always_comb begin
        if (r_size == '0) begin
            size = SIZE_W'(1);
        end else if (r_size > SIZE_MAX) begin
            size = SIZE_MAX;
        end else begin
            size = r_size;
        end
    end

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign prod  = r_k * RECIP_10;
    assign quo   = prod[63:35];
    assign digit = 4'(r_k - ({quo, 3'b000} + {2'b00, quo, 1'b0}));

    assign mod_t  = {r_rem, r_dvd[31]};
    assign mod_ge = (mod_t >= r_div);
    assign rem_nx = mod_ge ? IDX_W'(mod_t - r_div) : IDX_W'(mod_t);
    assign wrap_p1 = {1'b0, rem_nx} + SIZE_W'(1);

    assign p_sum = {1'b0, r_p} + {23'd0, r_h2};
    always_comb begin
        pos_a = {1'b0, r_pos} + {1'b0, r_h2m};
        if (pos_a >= size) begin
            pos_a = pos_a - size;
        end
        pos_b = pos_a;
        if (p_sum[32]) begin
            if (pos_a >= {1'b0, r_wrapc}) begin
                pos_b = pos_a - {1'b0, r_wrapc};
            end else begin
                pos_b = pos_a + size - {1'b0, r_wrapc};
            end
        end
        pos_c  = pos_b;
        pos_nx = pos_c[IDX_W-1:0];
    end

    assign key_eq     = (r_rdata.key == r_key);
    assign probe_last = (r_i + SIZE_W'(1) >= size);
    assign j_nx       = r_j + SIZE_W'(1);

    always_comb begin
        case (r_state)
            S_START: rd_addr = '0;
            S_MODW:  rd_addr = r_h1m;
            S_PROBE: rd_addr = (r_rdata.busy && !probe_last) ? pos_nx : r_pos;
            S_QSCAN: rd_addr = (j_nx >= size) ? r_j[IDX_W-1:0] : j_nx[IDX_W-1:0];
            default: rd_addr = r_pos;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pos;
        mem_wd = '{busy: 1'b1, key: r_key, rel: r_rel, value: r_value};
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_j[IDX_W-1:0];
            mem_wd = '0;
        end else if (r_state == S_PROBE && !r_rdata.busy && out_free) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_size    <= SIZE_RESET;
            r_entries <= '0;
            r_j       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_j <= j_nx;
                    if (r_j == SIZE_W'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= s_axis_tuser[0];
                        r_key   <= s_axis_tdata[31:0];
                        r_value <= s_axis_tdata[63:32];
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_req == REQ_QUERY) begin
                        r_j     <= '0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_ans   <= '0;
                        r_state <= S_QSCAN;
                    end else if (r_entries >= size) begin
                        if (out_free) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= ST_FULL;
                            r_oslot   <= '0;
                            r_orel    <= '0;
                            r_okey    <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        r_k     <= r_key[31] ? 32'd0 : r_key;
                        r_h1    <= H1_SEED;
                        r_dsum  <= '0;
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (r_k == '0) begin
                        r_rem <= '0;
                        r_cnt <= '0;
                        if (size == SIZE_W'(1)) begin
                            r_h2    <= IDX_W'(1);
                            r_h2m   <= '0;
                            r_dvd   <= r_h1;
                            r_div   <= size;
                            r_state <= S_MOD1;
                        end else begin
                            r_dvd   <= {25'd0, r_dsum};
                            r_div   <= size - SIZE_W'(1);
                            r_state <= S_MOD2;
                        end
                    end else begin
                        r_h1   <= (r_h1 << 5) + (r_h1 << 2) + r_h1 + {28'd0, digit};
                        r_dsum <= r_dsum + {3'd0, digit};
                        r_k    <= {3'd0, quo};
                    end
                end
                S_MOD2, S_MOD1, S_MODW: begin
                    r_rem <= rem_nx;
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_rem <= '0;
                        r_div <= size;
                        if (r_state == S_MOD2) begin
                            r_h2    <= rem_nx + IDX_W'(1);
                            r_h2m   <= rem_nx + IDX_W'(1);
                            r_dvd   <= r_h1;
                            r_state <= S_MOD1;
                        end else if (r_state == S_MOD1) begin
                            r_h1m   <= rem_nx;
                            r_dvd   <= 32'hFFFF_FFFF;
                            r_state <= S_MODW;
                        end else begin
                            r_wrapc <= (wrap_p1 == size) ? '0 : wrap_p1[IDX_W-1:0];
                            r_pos   <= r_h1m;
                            r_p     <= r_h1;
                            r_i     <= '0;
                            r_rel   <= '0;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (!r_rdata.busy) begin
                        if (out_free) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= ST_INSERTED;
                            r_oslot   <= r_pos;
                            r_orel    <= r_rel;
                            r_okey    <= '0;
                            r_entries <= r_entries + SIZE_W'(1);
                            r_state   <= S_IDLE;
                        end
                    end else if (probe_last) begin
                        if (out_free) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= ST_FULL;
                            r_oslot   <= '0;
                            r_orel    <= '0;
                            r_okey    <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        if (key_eq && r_rel != REL_MAX) begin
                            r_rel <= r_rel + REL_W'(1);
                        end
                        r_pos <= pos_nx;
                        r_p   <= p_sum[31:0];
                        r_i   <= r_i + SIZE_W'(1);
                    end
                end
                S_QSCAN: begin
                    if (j_nx >= size) begin
                        if (out_free) begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= ST_QUERY;
                            r_oslot   <= '0;
                            r_orel    <= '0;
                            if (r_rdata.busy && (!r_found || r_rdata.rel > r_best)) begin
                                r_okey <= r_rdata.key;
                            end else begin
                                r_okey <= r_ans;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_rdata.busy && (!r_found || r_rdata.rel > r_best)) begin
                            r_found <= 1'b1;
                            r_best  <= r_rdata.rel;
                            r_ans   <= r_rdata.key;
                        end
                        r_j <= j_nx;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {4'd0, r_okey, r_orel, r_oslot};

`ifndef SYNTHESIS
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= SIZE_MAX)
        else $error("entry count above capacity");
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ({1'b0, r_pos} < size))
        else $error("probe slot outside table");
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QSCAN) |-> (r_j < size))
        else $error("scan index outside table");
    a_write_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_PROBE) |=> (m_axis_tvalid && m_axis_tuser == ST_INSERTED))
        else $error("slot written without insert beat");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_double_hash_table_insert.sv =====
`timescale 1ns / 1ps
module tb_double_hash_table_insert;
    import dhti_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        logic [REL_W-1:0] rel;
        logic [31:0]      rkey;
    } t_answer;

    typedef struct {
        bit          is_cfg;
        logic [10:0] cfg_val;
        logic        req;
        logic [31:0] key;
        logic [31:0] val;
        bit          typed;
        t_answer     ans;
    } t_row;

    localparam t_answer ANS_EMPTY = '{ST_QUERY, '0, '0, '0};
    localparam t_answer ANS_FULL  = '{ST_FULL, '0, '0, '0};

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 0;
    wire  [55:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;

    double_hash_table_insert dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the table
    bit          tbl_busy [CAPACITY];
    logic [31:0] tbl_key  [CAPACITY];
    logic [9:0]  tbl_rel  [CAPACITY];
    int unsigned tbl_count = 0;
    logic [10:0] tbl_size_reg = SIZE_RESET;

    t_answer pending_answers[$];
    int      errors = 0;
    bit      quiet = 0;

    function automatic int unsigned live_size();
        if (tbl_size_reg == 0) return 1;
        if (tbl_size_reg > CAPACITY) return CAPACITY;
        return tbl_size_reg;
    endfunction

    function automatic t_answer table_apply(logic req, logic [31:0] key);
        t_answer     a;
        int unsigned sz;
        int          k;
        logic [31:0] h1, h2, dsum, pos;
        logic [9:0]  rel, best;
        bit          found;
        sz = live_size();
        a = '0;
        if (req == REQ_QUERY) begin
            a.status = ST_QUERY;
            found = 0;
            best = 0;
            for (int i = 0; i < sz; i++) begin
                if (tbl_busy[i] && (!found || tbl_rel[i] > best)) begin
                    found = 1;
                    best = tbl_rel[i];
                    a.rkey = tbl_key[i];
                end
            end
            return a;
        end
        a.status = ST_FULL;
        if (tbl_count >= sz) return a;
        k = $signed(key);
        h1 = H1_SEED;
        dsum = 0;
        while (k > 0) begin
            h1 = h1 * 37 + k % 10;
            dsum = dsum + k % 10;
            k = k / 10;
        end
        h2 = (sz != 1) ? 1 + dsum % (sz - 1) : 1;
        rel = 0;
        for (int unsigned i = 0; i < sz; i++) begin
            pos = h1 + i * h2;
            pos = pos % sz;
            if (!tbl_busy[pos]) begin
                tbl_busy[pos] = 1;
                tbl_key[pos] = key;
                tbl_rel[pos] = rel;
                tbl_count++;
                a.status = ST_INSERTED;
                a.slot = pos[9:0];
                a.rel = rel;
                return a;
            end
            if (tbl_key[pos] == key && rel < REL_MAX) rel++;
        end
        return a;
    endfunction

    task automatic write_size(logic [10:0] v);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        tbl_size_reg = v;
    endtask

    task automatic send_beat(logic req, logic [31:0] key, logic [31:0] val,
                             bit typed, t_answer typed_ans);
        t_answer a;
        s_axis_tvalid <= 1;
        s_axis_tuser <= req;
        s_axis_tdata <= {val, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        a = table_apply(req, key);
        pending_answers.push_back(typed ? typed_ans : a);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10],
                    m_axis_tdata[51:20]};
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.rel !== want.rel || got.rkey !== want.rkey) begin
                    $display("%0t: mismatch expected st=%0d slot=%0d rel=%0d key=%h",
                             $time, want.status, want.slot, want.rel, want.rkey);
                    $display("%0t:          actual   st=%0d slot=%0d rel=%0d key=%h",
                             $time, got.status, got.slot, got.rel, got.rkey);
                    errors++;
                end
            end
        end
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end

    t_row directed[] = '{
        '{0, 0, REQ_QUERY,  32'h0,        32'h0,        1, ANS_EMPTY},
        '{0, 0, REQ_INSERT, 32'h0,        32'h0,        0, '0},
        '{0, 0, REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0},
        '{0, 0, REQ_INSERT, 32'h80000000, 32'h80000000, 0, '0},
        '{0, 0, REQ_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0},
        '{0, 0, REQ_INSERT, 32'd7,        32'd1,        0, '0},
        '{0, 0, REQ_INSERT, 32'd7,        32'd2,        0, '0},
        '{0, 0, REQ_INSERT, 32'd7,        32'd3,        0, '0},
        '{0, 0, REQ_INSERT, 32'd7,        32'd4,        0, '0},
        '{0, 0, REQ_INSERT, 32'd70,       32'd5,        0, '0},
        '{0, 0, REQ_QUERY,  32'hA5A5A5A5, 32'h5A5A5A5A, 0, '0},
        '{0, 0, REQ_INSERT, 32'd1234567890, 32'd9,      0, '0},
        '{1, 11'd0, 0, 0, 0, 0, '0},
        '{0, 0, REQ_INSERT, 32'd5,        32'd5,        1, ANS_FULL},
        '{0, 0, REQ_QUERY,  32'h0,        32'h0,        0, '0},
        '{1, 11'd2047, 0, 0, 0, 0, '0},
        '{0, 0, REQ_QUERY,  32'h0,        32'h0,        0, '0},
        '{0, 0, REQ_INSERT, 32'd99,       32'd1,        0, '0},
        '{0, 0, REQ_INSERT, 32'd99,       32'd1,        0, '0}
    };

    logic [10:0] phase_sizes[] = '{11'd16, 11'd40, 11'd100, 11'd300, 11'd1021, 11'd1024,
                                   11'd2047};

    initial begin
        logic        req;
        logic [31:0] key;
        int          n;
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_busy[i] = 0;
            tbl_key[i] = 0;
            tbl_rel[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (directed[r]) begin
            if (directed[r].is_cfg) begin
                s_axis_tvalid <= 0;
                write_size(directed[r].cfg_val);
            end else begin
                send_beat(directed[r].req, directed[r].key, directed[r].val,
                          directed[r].typed, directed[r].ans);
            end
        end
        n = 0;
        foreach (phase_sizes[p]) begin
            s_axis_tvalid <= 0;
            write_size(phase_sizes[p]);
            for (int j = 0; j < 205; j++) begin
                quiet = (n >= 600 && n < 850);
                req = ($urandom_range(0, 99) < 12) ? REQ_QUERY : REQ_INSERT;
                case ($urandom_range(0, 4))
                    0, 1: key = $urandom_range(0, 30);
                    2: key = -$urandom_range(0, 1000);
                    default: key = $urandom;
                endcase
                send_beat(req, key, $urandom, 0, '0);
                n++;
            end
        end
        quiet = 0;
        s_axis_tvalid <= 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
